>>> rtl/osm_pkg.sv
// Shared constants, codes and types for the order-statistic multiset.
// Used by osm_cell and order_statistic_multiset; no dependencies.
`timescale 1ns / 1ps

package osm_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;
	localparam int MODE_W     = 2;
	localparam int RANK_W     = 7;
	localparam int STATUS_W   = 2;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMP_W      = (RANK_W > CNT_W) ? RANK_W : CNT_W;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ALIAS  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_RANK  = 2'd3;

	typedef logic signed [VALUE_BITS-1:0] value_t;

	// Command broadcast to every cell in the row.
	typedef struct packed {
		logic   ins_en;
		logic   del_en;
		value_t value;
	} cell_cmd_t;

	// Compare flags a cell hands to its neighbors and to the top level.
	typedef struct packed {
		logic pass;   // entry sits at or after the insert point
		logic hit;    // occupied and equal to the operand
	} cell_flags_t;

endpackage

>>> rtl/osm_cell.sv
// One slot of the sorted row: holds an entry, compares it with the operand
// and shifts toward either neighbor. Depends on osm_pkg.
`timescale 1ns / 1ps

module osm_cell
	import osm_pkg::*;
(
	input  logic        clk,
	input  cell_cmd_t   cmd,
	input  logic        occ,
	input  logic        sel,
	input  value_t      left_entry,
	input  logic        left_pass,
	input  value_t      right_entry,
	output value_t      entry,
	output cell_flags_t flags,
	output value_t      rd
);

	value_t entry_q;
	logic   gt;
	logic   lt;

	assign gt = entry_q > cmd.value;
	assign lt = entry_q < cmd.value;

	assign flags.pass = !occ || gt;
	assign flags.hit  = occ && !gt && !lt;

	assign entry = entry_q;
	assign rd    = sel ? entry_q : '0;

	// Insert: cells from the insert point on take the left neighbor or the operand.
	// Delete: cells from the first copy on take the right neighbor.
	always_ff @(posedge clk) begin
		if (cmd.ins_en && flags.pass) begin
			entry_q <= left_pass ? left_entry : cmd.value;
		end else if (cmd.del_en && occ && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule

>>> rtl/order_statistic_multiset.sv
// Order-statistic multiset: a row of osm_cell slots kept in ascending order,
// with the occupancy count and the registered result. Depends on osm_pkg, osm_cell.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, mode,        | into block
//           | value_in, rank                   |
//   out     | out_valid, out_stall, value_out, | out of block
//           | status                           |
//
// Each operation updates the row and the output register at the edge that accepts
// the beat, so the result is offered in the next cycle. The clock period is set
// by the parallel compare in every cell and the match reduction across the row.
// Reset clears the count and output valid only. in_stall rises only while a
// result is held and out_stall is high.
`timescale 1ns / 1ps

module order_statistic_multiset
	import osm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [MODE_W-1:0]     mode,
	input  logic signed [VALUE_BITS-1:0] value_in,
	input  logic [RANK_W-1:0]     rank,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [VALUE_BITS-1:0] value_out,
	output logic [STATUS_W-1:0]   status
);

	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	value_t              value_out_q;
	logic [STATUS_W-1:0] status_q;

	logic        accept;
	logic        full;
	logic        found;
	logic        rank_bad;
	logic        is_ins;
	logic        is_del;
	logic [CMP_W-1:0] rank_idx;
	value_t      rd_all;
	cell_cmd_t   cmd;

	value_t      entry [CAPACITY];
	value_t      rd    [CAPACITY];
	cell_flags_t flags [CAPACITY];
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] sel;
	logic [CAPACITY-1:0] hit;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		is_ins = 1'b0;
		is_del = 1'b0;
		unique case (mode) inside
			MODE_INSERT: is_ins = 1'b1;
			MODE_DELETE: is_del = 1'b1;
			MODE_FIND, MODE_ALIAS: ;
			default: ;
		endcase
	end

	assign full     = count_q == CNT_W'(CAPACITY);
	assign found    = |hit;
	assign rank_bad = (rank == '0) || (CMP_W'(rank) > CMP_W'(count_q));
	assign rank_idx = CMP_W'(rank) - CMP_W'(1);

	assign cmd.ins_en = accept && is_ins && !full;
	assign cmd.del_en = accept && is_del && found;
	assign cmd.value  = value_in;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			value_t left_e;
			logic   left_p;
			value_t right_e;

			assign occ[gi] = CNT_W'(gi) < count_q;
			assign sel[gi] = rank_idx == CMP_W'(gi);
			assign hit[gi] = flags[gi].hit;

			if (gi == 0) begin : g_first
				assign left_e = '0;
				assign left_p = 1'b0;
			end else begin : g_mid
				assign left_e = entry[gi-1];
				assign left_p = flags[gi-1].pass;
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign right_e = '0;
			end else begin : g_inner
				assign right_e = entry[gi+1];
			end

			osm_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occ        (occ[gi]),
				.sel        (sel[gi]),
				.left_entry (left_e),
				.left_pass  (left_p),
				.right_entry(right_e),
				.entry      (entry[gi]),
				.flags      (flags[gi]),
				.rd         (rd[gi])
			);
		end
	endgenerate

	// At most one cell is selected, so an OR gathers the read.
	always_comb begin
		rd_all = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_all = rd_all | rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.del_en) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_ins) begin
				value_out_q <= '0;
				status_q    <= full ? ST_FULL : ST_OK;
			end else if (is_del) begin
				value_out_q <= '0;
				status_q    <= found ? ST_OK : ST_ABSENT;
			end else begin
				value_out_q <= rank_bad ? '0 : rd_all;
				status_q    <= rank_bad ? ST_BAD_RANK : ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_out_q;
	assign status    = status_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("occupancy count above capacity");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted beat left no result");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count");

	a_row_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		occ[1] |-> entry[0] <= entry[1])
		else $error("first two entries out of order");
`endif

endmodule

>>> tb/order_statistic_multiset_tb.sv
// Self-checking testbench for order_statistic_multiset: directed table, then random
// traffic in idle/stall phases, each result checked against a table value or a
// sorted-array predictor. Depends on osm_pkg and the order_statistic_multiset RTL.
`timescale 1ns / 1ps

module order_statistic_multiset_tb;
	import osm_pkg::*;

	localparam int     PHASE_BEATS = 382;
	localparam int     HOLD_CYCLES = 300;
	localparam int     DIR_N       = 23;
	localparam value_t VAL_MIN     = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam value_t VAL_MAX     = ~VAL_MIN;

	typedef struct packed {
		value_t              val;
		logic [STATUS_W-1:0] st;
	} result_t;

	typedef struct packed {
		logic [MODE_W-1:0]   op;
		value_t              val;
		logic [RANK_W-1:0]   rk;
		logic                typed;
		value_t              want_val;
		logic [STATUS_W-1:0] want_st;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [MODE_W-1:0]   mode;
	value_t              value_in;
	logic [RANK_W-1:0]   rank;
	logic                out_valid;
	logic                out_stall;
	value_t              value_out;
	logic [STATUS_W-1:0] status;

	// Predictor state: the multiset as an ascending array
	value_t  held_vals [CAPACITY];
	int      held_cnt = 0;
	int      peak_cnt = 0;
	result_t pending_results [$];

	int       send_idle_pct = 0;
	int       stall_pct = 0;
	bit       hold_req = 1'b0;
	int       errors = 0;
	int       beats_sent = 0;
	int       results_checked = 0;
	int       status_seen [4] = '{0, 0, 0, 0};
	dir_row_t dir_rows [DIR_N];

	order_statistic_multiset u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.value_in  (value_in),
		.rank      (rank),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_out (value_out),
		.status    (status)
	);

	always #5 clk = ~clk;

	// Apply one operation to the predicted multiset and return its result.
	function automatic void multiset_apply(input logic [MODE_W-1:0] op, input value_t v,
			input logic [RANK_W-1:0] rk, output value_t vo, output logic [STATUS_W-1:0] st);
		int pos;
		vo = '0;
		st = ST_OK;
		pos = 0;
		if (op == MODE_INSERT) begin
			if (held_cnt >= CAPACITY) begin
				st = ST_FULL;
			end else begin
				// new copy goes after any equal entries
				while (pos < held_cnt && held_vals[pos] <= v) pos++;
				for (int i = held_cnt; i > pos; i--) held_vals[i] = held_vals[i-1];
				held_vals[pos] = v;
				held_cnt++;
				if (held_cnt > peak_cnt) peak_cnt = held_cnt;
			end
		end else if (op == MODE_DELETE) begin
			while (pos < held_cnt && held_vals[pos] < v) pos++;
			if (pos >= held_cnt || held_vals[pos] != v) begin
				st = ST_ABSENT;
			end else begin
				for (int i = pos; i < held_cnt - 1; i++) held_vals[i] = held_vals[i+1];
				held_cnt--;
			end
		end else begin
			// find and its alias selector
			if (rk == 0 || rk > held_cnt) st = ST_BAD_RANK;
			else vo = held_vals[rk-1];
		end
	endfunction

	function automatic value_t any_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return value_t'($urandom_range(16)) - value_t'(8);
			4: begin
				case ($urandom_range(3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return value_t'(-1);
				endcase
			end
			default: return value_t'($urandom);
		endcase
	endfunction

	function automatic logic [RANK_W-1:0] rank_pick();
		int sel;
		sel = $urandom_range(9);
		if (sel < 8) return RANK_W'($urandom_range(1, held_cnt > 0 ? held_cnt : 1));
		if (sel == 8) return RANK_W'($urandom_range(1) ? held_cnt + 1 : 0);
		return RANK_W'($urandom_range(127));
	endfunction

	// Offer one beat, hold it until accepted, then queue its expected result.
	task automatic drive_beat(input logic [MODE_W-1:0] op, input value_t v,
			input logic [RANK_W-1:0] rk, input logic typed, input value_t want_val,
			input logic [STATUS_W-1:0] want_st);
		result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		value_in <= v;
		rank     <= rk;
		do @(posedge clk); while (in_stall);
		multiset_apply(op, v, rk, r.val, r.st);
		if (typed) begin
			r.val = want_val;
			r.st  = want_st;
		end
		pending_results.push_back(r);
		beats_sent++;
	endtask

	// Result side: random stall, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: value_out %0d status %0d", value_out, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (value_out !== want.val) begin
					$error("value_out: expected %0d, got %0d", want.val, value_out);
					errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
				status_seen[want.st]++;
				results_checked++;
			end
		end
	end

	initial begin : main
		int                send_plan [4];
		int                stall_plan [4];
		int                pick;
		int                drain;
		logic [MODE_W-1:0] op;
		value_t            v;
		logic [RANK_W-1:0] rk;

		send_plan  = '{0, 70, 0, 30};
		stall_plan = '{0, 0, 70, 30};
		dir_rows = '{
			'{MODE_FIND,   value_t'(0),   7'd1,   1'b1, value_t'(0), ST_BAD_RANK},
			'{MODE_DELETE, value_t'(5),   7'd0,   1'b1, value_t'(0), ST_ABSENT},
			'{MODE_FIND,   value_t'(0),   7'd0,   1'b1, value_t'(0), ST_BAD_RANK},
			'{MODE_INSERT, VAL_MIN,       7'd0,   1'b1, value_t'(0), ST_OK},
			'{MODE_INSERT, VAL_MAX,       7'd0,   1'b1, value_t'(0), ST_OK},
			'{MODE_INSERT, value_t'(0),   7'd0,   1'b1, value_t'(0), ST_OK},
			'{MODE_INSERT, value_t'(-1),  7'd0,   1'b1, value_t'(0), ST_OK},
			'{MODE_INSERT, value_t'(0),   7'd0,   1'b1, value_t'(0), ST_OK},
			'{MODE_FIND,   value_t'(0),   7'd1,   1'b1, VAL_MIN,     ST_OK},
			'{MODE_FIND,   value_t'(0),   7'd5,   1'b1, VAL_MAX,     ST_OK},
			'{MODE_FIND,   value_t'(0),   7'd6,   1'b1, value_t'(0), ST_BAD_RANK},
			'{MODE_FIND,   value_t'(0),   7'd127, 1'b1, value_t'(0), ST_BAD_RANK},
			'{MODE_ALIAS,  value_t'(123), 7'd2,   1'b0, value_t'(0), ST_OK},
			'{MODE_DELETE, value_t'(0),   7'd0,   1'b0, value_t'(0), ST_OK},
			'{MODE_DELETE, value_t'(0),   7'd0,   1'b0, value_t'(0), ST_OK},
			'{MODE_DELETE, value_t'(0),   7'd0,   1'b1, value_t'(0), ST_ABSENT},
			'{MODE_DELETE, VAL_MIN,       7'd0,   1'b1, value_t'(0), ST_OK},
			'{MODE_DELETE, VAL_MIN,       7'd0,   1'b1, value_t'(0), ST_ABSENT},
			'{MODE_INSERT, value_t'(-1),  7'd127, 1'b0, value_t'(0), ST_OK},
			'{MODE_FIND,   VAL_MAX,       7'd2,   1'b0, value_t'(0), ST_OK},
			'{MODE_DELETE, VAL_MAX,       7'd0,   1'b0, value_t'(0), ST_OK},
			'{MODE_INSERT, VAL_MAX,       7'd0,   1'b0, value_t'(0), ST_OK},
			'{MODE_FIND,   value_t'(0),   7'd3,   1'b0, value_t'(0), ST_OK}
		};

		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		mode     <= MODE_INSERT;
		value_in <= '0;
		rank     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			drive_beat(dir_rows[i].op, dir_rows[i].val, dir_rows[i].rk, dir_rows[i].typed,
				dir_rows[i].want_val, dir_rows[i].want_st);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_plan[ph];
			stall_pct     = stall_plan[ph];
			// long hold-off while beats keep coming, so the block backs up
			if (ph == 0) hold_req = 1'b1;
			for (int i = 0; i < PHASE_BEATS; i++) begin
				pick = $urandom_range(99);
				// first half fills the store, second half drains it
				if (i < PHASE_BEATS / 2)
					op = pick < 60 ? MODE_INSERT : pick < 75 ? MODE_DELETE : MODE_FIND;
				else
					op = pick < 15 ? MODE_INSERT : pick < 70 ? MODE_DELETE : MODE_FIND;
				if (op == MODE_FIND && $urandom_range(3) == 0) op = MODE_ALIAS;
				if (op == MODE_DELETE && held_cnt > 0 && $urandom_range(9) < 7)
					v = held_vals[$urandom_range(held_cnt - 1)];
				else
					v = any_value();
				rk = rank_pick();
				drive_beat(op, v, rk, 1'b0, '0, ST_OK);
			end
			// pause the sender until every pending result is back
			in_valid <= 1'b0;
			do @(posedge clk); while (pending_results.size() != 0);
		end

		stall_pct = 0;
		drain = 0;
		while (pending_results.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (5) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			errors++;
		end

		$display("Covered %0d beats (%0d directed), %0d results checked, peak fill %0d of %0d.",
			beats_sent, DIR_N, results_checked, peak_cnt, CAPACITY);
		$display("Statuses: ok %0d, full %0d, absent %0d, bad rank %0d; four idle/stall phases.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
